### src/icms_pkg.sv
// ============================================================================
// icms_pkg
// Shared types, control word layout and microprogram for the inversion
// count merge sort unit.
// ============================================================================
package icms_pkg;

    // Inversion counter width, wraps modulo 2^11
    localparam int INV_W = 11;

    // Step counter
    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE       = 3'd0;
    localparam step_t STEP_PASS_CHK   = 3'd1;
    localparam step_t STEP_MERGE      = 3'd2;
    localparam step_t STEP_EMIT_SETUP = 3'd3;
    localparam step_t STEP_EMIT       = 3'd4;

    // Datapath operation selected by a control word
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_PASS,
        OP_MERGE,
        OP_EMIT_SETUP,
        OP_EMIT
    } op_e;

    // Jump condition
    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_START_LAST,
        COND_W_GE_N,
        COND_PASS_DONE,
        COND_EMIT_DONE
    } cond_e;

    typedef struct packed {
        logic  busy;
        op_e   op;
        cond_e cond;
        logic  hold;    // stay on this step when the condition is false
        step_t tgt;
    } ctrl_t;

    typedef struct packed {
        logic start_last;
        logic w_ge_n;
        logic pass_done;
        logic emit_done;
    } status_t;

    // Microprogram ROM
    function automatic ctrl_t ucode_word(input step_t s);
        ctrl_t w;
        unique case (s)
            STEP_IDLE:       w = '{1'b0, OP_LOAD,       COND_START_LAST, 1'b1, STEP_PASS_CHK};
            STEP_PASS_CHK:   w = '{1'b1, OP_PASS,       COND_W_GE_N,     1'b0, STEP_EMIT_SETUP};
            STEP_MERGE:      w = '{1'b1, OP_MERGE,      COND_PASS_DONE,  1'b1, STEP_PASS_CHK};
            STEP_EMIT_SETUP: w = '{1'b1, OP_EMIT_SETUP, COND_ALWAYS,     1'b0, STEP_EMIT};
            STEP_EMIT:       w = '{1'b1, OP_EMIT,       COND_EMIT_DONE,  1'b1, STEP_IDLE};
            default:         w = '{1'b1, OP_EMIT_SETUP, COND_ALWAYS,     1'b0, STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/icms_bank.sv
// ============================================================================
// icms_bank
// Element memory: one write port, two registered read ports.
// ============================================================================
module icms_bank #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         qa,
    output logic [WIDTH-1:0]         qb
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        qa <= mem[raddr_a];
        qb <= mem[raddr_b];
    end

endmodule

### src/icms_datapath.sv
// ============================================================================
// icms_datapath
// Pointers, counters and ping-pong element banks driven by the control word.
// ============================================================================
module icms_datapath #(
    parameter int MAX_N      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  icms_pkg::ctrl_t                ctrl,
    input  logic                           start,
    input  logic signed [DATA_WIDTH-1:0]   value,
    input  logic                           last,
    output icms_pkg::status_t              status,
    output logic                           result_valid,
    output logic signed [DATA_WIDTH-1:0]   sorted_value,
    output logic [icms_pkg::INV_W-1:0]     inversion_total,
    output logic                           overflow,
    output logic                           last_out
);

    localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int CW = IW + 2;
    localparam int FW = $clog2(MAX_N + 1);

    logic [FW-1:0]               fill_reg, fill_next;
    logic [icms_pkg::INV_W-1:0]  inv_reg, inv_next;
    logic                        ovf_reg, ovf_next;
    logic                        bank_reg, bank_next;
    logic [CW-1:0]               w_reg, w_next;
    logic [CW-1:0]               a_reg, a_next;
    logic [CW-1:0]               b_reg, b_next;
    logic [CW-1:0]               mid_reg, mid_next;
    logic [CW-1:0]               hi_reg, hi_next;
    logic [CW-1:0]               k_reg, k_next;

    logic [CW-1:0]               n;
    logic                        accept;
    logic                        a_act, b_act, take_a, run_end;
    logic signed [DATA_WIDTH-1:0] q_a, q_b;
    logic [DATA_WIDTH-1:0]       b0_qa, b0_qb, b1_qa, b1_qb;
    logic                        b0_we, b1_we;
    logic [IW-1:0]               b0_waddr;
    logic [DATA_WIDTH-1:0]       b0_wdata, merge_data;

    function automatic logic [CW-1:0] clip(input logic [CW-1:0] x, input logic [CW-1:0] lim);
        return (x > lim) ? lim : x;
    endfunction

    assign n       = CW'(fill_reg);
    assign accept  = start && !ctrl.busy;
    assign q_a     = bank_reg ? b1_qa : b0_qa;
    assign q_b     = bank_reg ? b1_qb : b0_qb;
    assign a_act   = a_reg < mid_reg;
    assign b_act   = b_reg < hi_reg;
    assign take_a  = a_act && (!b_act || (q_a <= q_b));
    assign run_end = (k_reg == (hi_reg - CW'(1)));
    assign merge_data = take_a ? q_a : q_b;

    assign status.start_last = accept && last;
    assign status.w_ge_n     = w_reg >= n;
    assign status.pass_done  = run_end && (hi_reg == n);
    assign status.emit_done  = a_reg == (n - CW'(1));

    always_comb
    begin
        fill_next = fill_reg;
        inv_next  = inv_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        w_next    = w_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        mid_next  = mid_reg;
        hi_next   = hi_reg;
        k_next    = k_reg;
        b0_we     = 1'b0;
        b1_we     = 1'b0;
        b0_waddr  = k_reg[IW-1:0];
        b0_wdata  = merge_data;

        unique case (ctrl.op)
            icms_pkg::OP_LOAD:
            begin
                if (accept)
                begin
                    if (fill_reg < FW'(MAX_N))
                    begin
                        b0_we     = 1'b1;
                        b0_waddr  = fill_reg[IW-1:0];
                        b0_wdata  = value;
                        fill_next = fill_reg + FW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            icms_pkg::OP_PASS:
            begin
                a_next   = '0;
                k_next   = '0;
                mid_next = clip(w_reg, n);
                b_next   = clip(w_reg, n);
                hi_next  = clip(w_reg << 1, n);
            end
            icms_pkg::OP_MERGE:
            begin
                b0_we  = bank_reg;
                b1_we  = !bank_reg;
                k_next = k_reg + CW'(1);
                if (take_a)
                begin
                    a_next = a_reg + CW'(1);
                end
                else
                begin
                    b_next   = b_reg + CW'(1);
                    inv_next = inv_reg + icms_pkg::INV_W'(mid_reg - a_reg);
                end
                if (run_end)
                begin
                    if (hi_reg == n)
                    begin
                        bank_next = !bank_reg;
                        w_next    = w_reg << 1;
                    end
                    else
                    begin
                        // next run opens where this one closed
                        a_next   = hi_reg;
                        k_next   = hi_reg;
                        mid_next = clip(hi_reg + w_reg, n);
                        b_next   = clip(hi_reg + w_reg, n);
                        hi_next  = clip(hi_reg + (w_reg << 1), n);
                    end
                end
            end
            icms_pkg::OP_EMIT_SETUP:
            begin
                a_next = '0;
            end
            icms_pkg::OP_EMIT:
            begin
                a_next = a_reg + CW'(1);
                if (status.emit_done)
                begin
                    fill_next = '0;
                    inv_next  = '0;
                    ovf_next  = 1'b0;
                    bank_next = 1'b0;
                    w_next    = CW'(1);
                end
            end
            default:
            begin
                a_next = a_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            inv_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
            w_reg    <= CW'(1);
            a_reg    <= '0;
            b_reg    <= '0;
            mid_reg  <= '0;
            hi_reg   <= '0;
            k_reg    <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            inv_reg  <= inv_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
            w_reg    <= w_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            mid_reg  <= mid_next;
            hi_reg   <= hi_next;
            k_reg    <= k_next;
        end
    end

    // read addresses follow the next pointers so heads are ready next cycle
    icms_bank #(.DEPTH(MAX_N), .WIDTH(DATA_WIDTH)) u_bank0 (
        .clk     (clk),
        .we      (b0_we),
        .waddr   (b0_waddr),
        .wdata   (b0_wdata),
        .raddr_a (a_next[IW-1:0]),
        .raddr_b (b_next[IW-1:0]),
        .qa      (b0_qa),
        .qb      (b0_qb)
    );

    icms_bank #(.DEPTH(MAX_N), .WIDTH(DATA_WIDTH)) u_bank1 (
        .clk     (clk),
        .we      (b1_we),
        .waddr   (k_reg[IW-1:0]),
        .wdata   (merge_data),
        .raddr_a (a_next[IW-1:0]),
        .raddr_b (b_next[IW-1:0]),
        .qa      (b1_qa),
        .qb      (b1_qb)
    );

    assign result_valid    = (ctrl.op == icms_pkg::OP_EMIT);
    assign sorted_value    = q_a;
    assign inversion_total = inv_reg;
    assign overflow        = ovf_reg;
    assign last_out        = result_valid && status.emit_done;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(MAX_N))
        else $error("fill count past capacity");

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == icms_pkg::OP_EMIT && status.emit_done)
        |=> (fill_reg == '0 && inv_reg == '0 && !ovf_reg && !bank_reg))
        else $error("set state not cleared after final result");

    a_merge_k_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == icms_pkg::OP_MERGE) |-> (k_reg < hi_reg && k_reg == a_reg + b_reg - mid_reg))
        else $error("merge write pointer out of step with run heads");

    a_merge_left_head: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == icms_pkg::OP_MERGE) |-> (a_reg <= mid_reg && mid_reg <= b_reg))
        else $error("left run head passed its midpoint");
`endif

endmodule

### src/icms_sequencer.sv
// ============================================================================
// icms_sequencer
// Step counter over the microprogram ROM with conditional jumps.
// ============================================================================
module icms_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  icms_pkg::status_t status,
    output icms_pkg::ctrl_t   ctrl
);

    icms_pkg::step_t step_reg, step_next;
    logic            jump;

    assign ctrl = icms_pkg::ucode_word(step_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            icms_pkg::COND_ALWAYS:     jump = 1'b1;
            icms_pkg::COND_START_LAST: jump = status.start_last;
            icms_pkg::COND_W_GE_N:     jump = status.w_ge_n;
            icms_pkg::COND_PASS_DONE:  jump = status.pass_done;
            icms_pkg::COND_EMIT_DONE:  jump = status.emit_done;
            default:                   jump = 1'b1;
        endcase

        priority if (jump)
        begin
            step_next = ctrl.tgt;
        end
        else if (ctrl.hold)
        begin
            step_next = step_reg;
        end
        else
        begin
            step_next = step_reg + icms_pkg::step_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= icms_pkg::STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### src/inversion_count_merge_sort_unit.sv
// ============================================================================
// inversion_count_merge_sort_unit
// Loads a set of signed values, merge-sorts it and counts inversions.
// ============================================================================
// Usage:
//   Input: raise start with value/last while busy is low; each such edge is
//   one transaction. The transaction with last=1 closes the set and busy
//   rises on the next cycle. Elements past MAX_N are dropped and set the
//   overflow flag.
//   Sort: bottom-up merge passes, each a pass check step then a merge
//   step, one merged element per cycle (one write per bank per cycle sets
//   this), for ceil(log2 n) passes. Then a final pass check, a read setup
//   step and the n results.
//   Output: result_valid marks each result for exactly one cycle; the
//   values come in ascending order with inversion_total and overflow
//   repeated on each and last_out on the final one. The receiver cannot
//   stall. busy drops after the final result; a new set may start then.
//   Reset: asynchronous, active low; clears the step counter, fill count,
//   inversion counter and overflow flag. Element banks are not cleared.
// ============================================================================
module inversion_count_merge_sort_unit #(
    parameter int MAX_N      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] value,
    input  logic                         last,
    output logic                         busy,
    output logic                         result_valid,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic [icms_pkg::INV_W-1:0]   inversion_total,
    output logic                         overflow,
    output logic                         last_out
);

    icms_pkg::ctrl_t   ctrl;     // current microinstruction
    icms_pkg::status_t status;   // datapath flags for the jump logic

    // busy comes straight from the control word; only the idle step clears it
    assign busy = ctrl.busy;

    icms_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // two banks ping-pong between merge passes; bank select lives here too
    icms_datapath #(
        .MAX_N      (MAX_N),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctrl            (ctrl),
        .start           (start),
        .value           (value),
        .last            (last),
        .status          (status),
        .result_valid    (result_valid),
        .sorted_value    (sorted_value),
        .inversion_total (inversion_total),
        .overflow        (overflow),
        .last_out        (last_out)
    );

endmodule
